>>> rtl/core/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

    // first candidate of the 6k-1 / 6k+1 sweep and its stride
    localparam int unsigned FIRST_DIVISOR = 5;
    localparam int unsigned DIVISOR_STEP  = 6;
    localparam int unsigned PAIR_GAP      = 2;
    // values up to this one are settled without any division
    localparam int unsigned SMALL_LIMIT   = 3;
    localparam int unsigned SMALL_ODD_DIV = 3;

    // request from the sequencer to the remainder unit
    typedef struct packed {
        logic go;
    } t_div_req;

    // status back from the remainder unit
    typedef struct packed {
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

>>> rtl/core/ptd_rem.sv
`default_nettype none

module ptd_rem #(
    parameter int NW = 31,
    parameter int DW = 17
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire ptd_pkg::t_div_req  i_req,
    input  wire  [NW-1:0]           i_dividend,
    input  wire  [DW-1:0]           i_divisor,
    output ptd_pkg::t_div_sts       o_sts,
    output logic [NW-1:0]           o_quot,
    output logic [DW-1:0]           o_rem
);
    import ptd_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic          r_run;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_dvsr;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_fit;

    // restoring step, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvsr};
    assign w_fit   = w_trial >= {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_run  <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvsr <= i_divisor;
            end else if (r_run) begin
                r_rem <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_quo <= {r_quo[NW-2:0], w_fit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_quot     = r_quo;
    assign o_rem      = r_rem;

endmodule

`default_nettype wire

>>> rtl/core/prime_trial_division_test.sv
// channel   ports                      handshake
// ------    -----------------------    ---------------------------------------
// in word   i_value                    taken at an edge with start high, busy low
// out word  o_is_prime                 shown for one cycle while o_done is high
//
// negative values, values below 4 and even values answer in the cycle after start
// every other value runs through one shared remainder unit, one quotient bit a
// cycle: a prime needs 2 + 2*floor((isqrt(n)+1)/6) remainders, and busy stays
// high meanwhile
// synchronous active-low reset returns to idle with no result pending
// the receiver cannot stall: o_done is a single-cycle pulse
`default_nettype none

module prime_trial_division_test #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [VALUE_WIDTH-1:0] i_value,
    output logic                         o_done,
    output logic                         o_is_prime
);
    import ptd_pkg::*;

    localparam int NW = VALUE_WIDTH - 1;
    localparam int DW = VALUE_WIDTH / 2 + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT3,
        ST_WAIT_LO,
        ST_WAIT_HI
    } t_state;

    t_state        r_state, n_state;
    logic [NW-1:0] r_n, n_n;
    logic [DW-1:0] r_d, n_d;
    logic [DW-1:0] r_dvsr, n_dvsr;
    logic          r_go, n_go;
    logic          r_done, n_done;
    logic          r_prime, n_prime;

    t_div_req      w_req;
    t_div_sts      w_sts;
    logic [NW-1:0] w_quot;
    logic [DW-1:0] w_rem;
    logic [NW-1:0] w_low;
    logic          w_zero;

    assign w_req.go = r_go;
    assign w_low    = i_value[NW-1:0];
    assign w_zero   = w_rem == '0;

    ptd_rem #(
        .NW (NW),
        .DW (DW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (r_n),
        .i_divisor  (r_dvsr),
        .o_sts      (w_sts),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_d     = r_d;
        n_dvsr  = r_dvsr;
        n_go    = 1'b0;
        n_done  = 1'b0;
        n_prime = r_prime;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_n = w_low;
                    if (i_value[VALUE_WIDTH-1] || w_low <= NW'(1)) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                    end else if (w_low <= NW'(SMALL_LIMIT)) begin
                        n_done  = 1'b1;
                        n_prime = 1'b1;
                    end else if (!w_low[0]) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                    end else begin
                        n_go    = 1'b1;
                        n_dvsr  = DW'(SMALL_ODD_DIV);
                        n_state = ST_WAIT3;
                    end
                end
            end
            ST_WAIT3: begin
                if (w_sts.done) begin
                    if (w_zero) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_d     = DW'(FIRST_DIVISOR);
                        n_dvsr  = DW'(FIRST_DIVISOR);
                        n_go    = 1'b1;
                        n_state = ST_WAIT_LO;
                    end
                end
            end
            ST_WAIT_LO: begin
                if (w_sts.done) begin
                    if (w_quot < NW'(r_d)) begin
                        n_done  = 1'b1;
                        n_prime = 1'b1;
                        n_state = ST_IDLE;
                    end else if (w_zero) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_dvsr  = r_d + DW'(PAIR_GAP);
                        n_go    = 1'b1;
                        n_state = ST_WAIT_HI;
                    end
                end
            end
            ST_WAIT_HI: begin
                if (w_sts.done) begin
                    if (w_zero) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_d     = r_d + DW'(DIVISOR_STEP);
                        n_dvsr  = r_d + DW'(DIVISOR_STEP);
                        n_go    = 1'b1;
                        n_state = ST_WAIT_LO;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_done  <= n_done;
        end
        r_n     <= n_n;
        r_d     <= n_d;
        r_dvsr  <= n_dvsr;
        r_prime <= n_prime;
    end

    assign busy       = r_state != ST_IDLE;
    assign o_done     = r_done;
    assign o_is_prime = r_prime;

endmodule

`default_nettype wire

>>> rtl/core/ptd_checker.sv
`default_nettype none

module ptd_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   start,
    input wire                   busy,
    input wire [VALUE_WIDTH-1:0] i_value,
    input wire                   o_done,
    input wire                   o_is_prime
);
    import ptd_pkg::*;

    // a result word never shows while a test is still running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word while busy");

    // negative words answer at once with not prime
    a_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_value[VALUE_WIDTH-1]) |=> (o_done && !o_is_prime && !busy))
        else $error("negative word not rejected at once");

    // small primes answer at once
    a_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_value[VALUE_WIDTH-1]
         && (i_value[VALUE_WIDTH-2:0] == (VALUE_WIDTH-1)'(2)
             || i_value[VALUE_WIDTH-2:0] == (VALUE_WIDTH-1)'(SMALL_LIMIT)))
        |=> (o_done && o_is_prime))
        else $error("small prime not reported");

    // busy only rises on an accepted word
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without start");

    // every run ends with a result word
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("run ended without result word");

endmodule

bind prime_trial_division_test ptd_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ptd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_value    (i_value),
    .o_done     (o_done),
    .o_is_prime (o_is_prime)
);

`default_nettype wire

>>> tb/sv/prime_trial_division_test_tb.sv
`default_nettype none

module prime_trial_division_test_tb;
    import ptd_pkg::*;

    localparam int VALUE_WIDTH = 32;
    localparam int RANDOM_WORDS = 75;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 64;
    localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] value;
        bit                            is_prime;
    } t_prime_check;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic signed [VALUE_WIDTH-1:0] i_value = '0;
    wire                           busy;
    wire                           o_done;
    wire                           o_is_prime;

    t_prime_check    primality_q[$];
    t_prime_check    oldest_check;
    t_prime_check    new_check;
    int unsigned     mismatches = 0;
    longint unsigned cycle_count = 0;

    prime_trial_division_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_value   (i_value),
        .o_done    (o_done),
        .o_is_prime(o_is_prime)
    );

    always #6 i_clk = ~i_clk;

    // 6k-1 / 6k+1 trial division with an exact divisor bound
    function automatic bit calc_is_prime(input logic signed [VALUE_WIDTH-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v[VALUE_WIDTH-1]) return 1'b0;
        n = {{(64-VALUE_WIDTH){1'b0}}, v};
        if (n <= 1) return 1'b0;
        if (n <= SMALL_LIMIT) return 1'b1;
        if (n % 2 == 0 || n % SMALL_ODD_DIV == 0) return 1'b0;
        for (d = FIRST_DIVISOR; d <= n / d; d += DIVISOR_STEP) begin
            if (n % d == 0 || n % (d + PAIR_GAP) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("prime_trial_division_test_tb failed");
            $finish;
        end
    end

    // result check first, then record the word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (primality_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected word: is_prime %b", o_is_prime);
                end else begin
                    oldest_check = primality_q.pop_front();
                    if (o_is_prime !== oldest_check.is_prime) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("value %0d: expected is_prime %b, got %b",
                                     oldest_check.value, oldest_check.is_prime, o_is_prime);
                    end
                end
            end
            if (start && !busy) begin
                new_check.value = i_value;
                new_check.is_prime = calc_is_prime(i_value);
                primality_q.push_back(new_check);
            end
        end
    end

    task automatic send_word(input logic signed [VALUE_WIDTH-1:0] v);
        @(negedge i_clk);
        start <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic test_small_values();
        int vals[18] = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 15, 25, 35, 49, 121, 143, 169,
                         999983, 1000001};
        foreach (vals[k]) send_word(vals[k]);
    endtask

    task automatic test_negative_values();
        int vals[4] = '{-1, -2, -3, 32'sh8000_0000};
        foreach (vals[k]) send_word(vals[k]);
    endtask

    // largest prime of the range runs the divisor bound up to the top
    task automatic test_top_of_range();
        int vals[3] = '{2147483646, 2147483645, 2147483647};
        foreach (vals[k]) send_word(vals[k]);
    endtask

    // mostly cheap words: negatives, evens, small factors, prime squares, small and medium values
    task automatic test_random_mix();
        int burst_left;
        int unsigned p;
        int unsigned q;
        logic signed [VALUE_WIDTH-1:0] v;
        burst_left = 0;
        repeat (RANDOM_WORDS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
            end
            burst_left--;
            case ($urandom_range(0, 9))
                0, 1: v = {1'b1, (VALUE_WIDTH-1)'($urandom)};
                2: v = {1'b0, (VALUE_WIDTH-2)'($urandom), 1'b0};
                3, 4: begin
                    case ($urandom_range(0, 3))
                        0: p = 5;
                        1: p = 7;
                        2: p = 11;
                        default: p = 13;
                    endcase
                    q = $urandom_range(1, 32'h7fff_ffff / p);
                    v = p * q;
                end
                5, 6, 7: v = $urandom_range(0, 4095);
                8: v = $urandom_range(0, 65535);
                default: begin
                    case ($urandom_range(0, 3))
                        0: p = 101;
                        1: p = 211;
                        2: p = 331;
                        default: p = 997;
                    endcase
                    v = p * p;
                end
            endcase
            send_word(v);
        end
        idle_cycles(1);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_small_values();
        test_negative_values();
        test_top_of_range();
        test_random_mix();
        while (primality_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("prime_trial_division_test_tb passed");
        end else begin
            $display("prime_trial_division_test_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/ptd_pkg.sv
rtl/core/ptd_rem.sv
rtl/core/prime_trial_division_test.sv
rtl/core/ptd_checker.sv
tb/sv/prime_trial_division_test_tb.sv
